// ----- sv/button_autorepeat_sampler_macros.svh -----
// assertion macros for the button auto-repeat sampler
`ifndef BUTTON_AUTOREPEAT_SAMPLER_MACROS_SVH
`define BUTTON_AUTOREPEAT_SAMPLER_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define BAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button_autorepeat_sampler: assertion failed");

// consequent checked in the same cycle
`define BAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button_autorepeat_sampler: assertion failed");

`endif

// ----- sv/bas_pkg.sv -----
// types and constants of the button auto-repeat sampler
package bas_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [TICK_W-1:0]  TICK_MAX  = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic [COUNT_W-1:0] MEDIUM_AFTER = 8'd4;
  localparam logic [COUNT_W-1:0] FAST_AFTER   = 8'd24;

  localparam logic [TICK_W-1:0] INITIAL_RESET = 16'd60;
  localparam logic [TICK_W-1:0] MEDIUM_RESET  = 16'd150;
  localparam logic [TICK_W-1:0] FAST_RESET    = 16'd18;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_INITIAL = 2'd0,
    REG_MEDIUM  = 2'd1,
    REG_FAST    = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    IV_INITIAL = 2'd0,
    IV_MEDIUM  = 2'd1,
    IV_FAST    = 2'd2
  } interval_t;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_UP    = 2'd1,
    BTN_DOWN  = 2'd2,
    BTN_ALARM = 2'd3
  } button_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NOT_SAMPLED = 3'd0,
    EV_IDLE        = 3'd1,
    EV_UP_PRESS    = 3'd2,
    EV_DOWN_PRESS  = 3'd3,
    EV_ALARM_PRESS = 3'd4,
    EV_UP_REL      = 3'd5,
    EV_DOWN_REL    = 3'd6,
    EV_ALARM_REL   = 3'd7
  } event_t;

  // press code is button + 1, release code is button + 4
  localparam logic [EVENT_W-1:0] EV_PRESS_BASE   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_RELEASE_BASE = 3'd4;

endpackage

// ----- sv/button_autorepeat_sampler.sv -----
// top level of the button auto-repeat sampler
//
// Each input beat is one timer tick carrying the three active-low button
// levels (up_level, down_level, alarm_level); it is accepted when in_valid
// and in_ready are both high. Every input beat yields exactly one output
// beat with event_res and held_count, offered on out_valid/out_ready.
// The tick, interval and press state is updated at the accepting edge by
// a single compare-and-select pass, and the result lands in the output
// register; throughput is one beat per cycle unless the receiver stalls.
// in_ready stays high while the output register is empty or being taken,
// so a stalled receiver holds the result and blocks only further input.
// The user writes the three interval registers through cfg_wr_en, cfg_index
// and cfg_data only while idle, unchecked here; an unknown index is ignored.
// Synchronous reset rst restores the interval defaults (60, 150, 18),
// clears the tick and press counters, selects the initial interval,
// drops any pending release and empties the output register.
`include "button_autorepeat_sampler_macros.svh"

module button_autorepeat_sampler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [bas_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bas_pkg::TICK_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            up_level,
  input  logic                            down_level,
  input  logic                            alarm_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bas_pkg::EVENT_W-1:0]     event_res,
  output logic [bas_pkg::COUNT_W-1:0]     held_count
);

  logic [bas_pkg::TICK_W-1:0] initial_interval;
  logic [bas_pkg::TICK_W-1:0] medium_interval;
  logic [bas_pkg::TICK_W-1:0] fast_interval;

  logic [bas_pkg::TICK_W-1:0]  tick_count, tick_count_next;
  bas_pkg::interval_t          interval_choice, interval_choice_next;
  logic [bas_pkg::COUNT_W-1:0] press_count, press_count_next;
  bas_pkg::button_t            pending_release, pending_release_next;

  logic [bas_pkg::TICK_W-1:0]  tick_inc;
  logic [bas_pkg::TICK_W-1:0]  cur_interval;
  logic [bas_pkg::COUNT_W-1:0] press_inc;
  logic                        sample;
  bas_pkg::button_t            button;
  logic [bas_pkg::EVENT_W-1:0] event_next;
  logic                        in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_interval <= bas_pkg::INITIAL_RESET;
      medium_interval  <= bas_pkg::MEDIUM_RESET;
      fast_interval    <= bas_pkg::FAST_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bas_pkg::REG_INITIAL: initial_interval <= cfg_data;
        bas_pkg::REG_MEDIUM:  medium_interval  <= cfg_data;
        bas_pkg::REG_FAST:    fast_interval    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_inc = (tick_count != bas_pkg::TICK_MAX) ? tick_count + 1'b1 : tick_count;
    press_inc = (press_count != bas_pkg::COUNT_MAX) ? press_count + 1'b1 : press_count;

    case (interval_choice)
      bas_pkg::IV_MEDIUM: cur_interval = medium_interval;
      bas_pkg::IV_FAST:   cur_interval = fast_interval;
      default:            cur_interval = initial_interval;
    endcase

    sample = (tick_inc >= cur_interval);

    if (!up_level)         button = bas_pkg::BTN_UP;
    else if (!down_level)  button = bas_pkg::BTN_DOWN;
    else if (!alarm_level) button = bas_pkg::BTN_ALARM;
    else                   button = bas_pkg::BTN_NONE;

    tick_count_next      = tick_inc;
    interval_choice_next = interval_choice;
    press_count_next     = press_count;
    pending_release_next = pending_release;
    event_next           = bas_pkg::EV_NOT_SAMPLED;

    if (sample) begin
      tick_count_next = '0;
      if (button == bas_pkg::BTN_NONE) begin
        event_next = bas_pkg::EV_IDLE;
        if (pending_release != bas_pkg::BTN_NONE) begin
          event_next = {1'b0, pending_release} + bas_pkg::EV_RELEASE_BASE;
          pending_release_next = bas_pkg::BTN_NONE;
          press_count_next     = '0;
          interval_choice_next = bas_pkg::IV_INITIAL;
        end
      end else begin
        press_count_next = press_inc;
        if (press_inc > bas_pkg::FAST_AFTER) begin
          interval_choice_next = bas_pkg::IV_FAST;
        end else if (press_inc > bas_pkg::MEDIUM_AFTER) begin
          interval_choice_next = bas_pkg::IV_MEDIUM;
        end
        pending_release_next = button;
        event_next = {1'b0, button} + bas_pkg::EV_PRESS_BASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      interval_choice <= bas_pkg::IV_INITIAL;
      press_count     <= '0;
      pending_release <= bas_pkg::BTN_NONE;
    end else if (in_fire) begin
      tick_count      <= tick_count_next;
      interval_choice <= interval_choice_next;
      press_count     <= press_count_next;
      pending_release <= pending_release_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_res  <= event_next;
      held_count <= press_count;
    end
  end

  // assertions
  `BAS_ASSERT_NEXT(a_beat_out, in_fire, out_valid)
  `BAS_ASSERT_NEXT(a_sample_clears_tick, in_fire && sample, tick_count == '0)
  `BAS_ASSERT_NOW(a_idle_interval, press_count == '0, interval_choice == bas_pkg::IV_INITIAL)
  `BAS_ASSERT_NEXT(a_release_clears, in_fire && (event_next >= bas_pkg::EV_UP_REL),
                   press_count == '0 && pending_release == bas_pkg::BTN_NONE)

endmodule

// ----- tb/sv/button_autorepeat_sampler_test.sv -----
// self-checking testbench for the button auto-repeat sampler
module button_autorepeat_sampler_test;
  import bas_pkg::*;

  localparam int unsigned RUN_LIMIT_CYCLES = 4_000_000;
  localparam int unsigned MAX_PRINTED = 100;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic up;
    logic down;
    logic alarm;
  } levels_t;

  typedef struct {
    event_t             ev;
    logic [COUNT_W-1:0] count;
  } sample_result_t;

  // priority order, change while held, release of the last button seen
  localparam levels_t DIRECTED_TICKS[20] = '{
    3'b111, 3'b011, 3'b000, 3'b100, 3'b110, 3'b111, 3'b101, 3'b001, 3'b111, 3'b010,
    3'b111, 3'b110, 3'b111, 3'b111, 3'b011, 3'b011, 3'b011, 3'b011, 3'b011, 3'b011
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic up_level = 1'b1;
  logic down_level = 1'b1;
  logic alarm_level = 1'b1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [EVENT_W-1:0] event_res;
  logic [COUNT_W-1:0] held_count;

  // expected interval registers and sampler state
  logic [TICK_W-1:0] iv_initial = INITIAL_RESET;
  logic [TICK_W-1:0] iv_medium = MEDIUM_RESET;
  logic [TICK_W-1:0] iv_fast = FAST_RESET;
  logic [TICK_W-1:0] tick_cnt = '0;
  interval_t iv_sel = IV_INITIAL;
  logic [COUNT_W-1:0] press_cnt = '0;
  button_t last_btn = BTN_NONE;

  levels_t tick_queue[$];
  sample_result_t awaited_samples[$];
  int unsigned ticks_queued = 0;
  int unsigned mismatch_count = 0;
  bit beat_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_off_left = 0;
  int unsigned stall_pct = 0;
  int unsigned mode_left = 0;

  button_autorepeat_sampler uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .up_level(up_level),
    .down_level(down_level),
    .alarm_level(alarm_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_res(event_res),
    .held_count(held_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic sample_result_t predict_sample(levels_t lv);
    sample_result_t r;
    button_t btn;
    logic [TICK_W-1:0] period;
    r.count = press_cnt;
    r.ev = EV_NOT_SAMPLED;
    if (tick_cnt != TICK_MAX) tick_cnt++;
    case (iv_sel)
      IV_MEDIUM: period = iv_medium;
      IV_FAST: period = iv_fast;
      default: period = iv_initial;
    endcase
    if (tick_cnt >= period) begin
      tick_cnt = '0;
      if (!lv.up) btn = BTN_UP;
      else if (!lv.down) btn = BTN_DOWN;
      else if (!lv.alarm) btn = BTN_ALARM;
      else btn = BTN_NONE;
      if (btn == BTN_NONE) begin
        r.ev = EV_IDLE;
        if (last_btn != BTN_NONE) begin
          case (last_btn)
            BTN_UP: r.ev = EV_UP_REL;
            BTN_DOWN: r.ev = EV_DOWN_REL;
            default: r.ev = EV_ALARM_REL;
          endcase
          last_btn = BTN_NONE;
          press_cnt = '0;
          iv_sel = IV_INITIAL;
        end
      end else begin
        if (press_cnt != COUNT_MAX) press_cnt++;
        if (press_cnt > FAST_AFTER) iv_sel = IV_FAST;
        else if (press_cnt > MEDIUM_AFTER) iv_sel = IV_MEDIUM;
        last_btn = btn;
        case (btn)
          BTN_UP: r.ev = EV_UP_PRESS;
          BTN_DOWN: r.ev = EV_DOWN_PRESS;
          default: r.ev = EV_ALARM_PRESS;
        endcase
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("mismatch: %s", msg);
  endtask

  task automatic queue_tick(levels_t lv);
    tick_queue.push_back(lv);
    ticks_queued++;
  endtask

  task automatic add_hold(button_t b, int unsigned n);
    levels_t lv;
    repeat (n) begin
      lv = levels_t'($urandom_range(0, 7));
      case (b)
        BTN_UP: lv.up = 1'b0;
        BTN_DOWN: begin
          lv.up = 1'b1;
          lv.down = 1'b0;
        end
        default: begin
          lv.up = 1'b1;
          lv.down = 1'b1;
          lv.alarm = 1'b0;
        end
      endcase
      queue_tick(lv);
    end
  endtask

  task automatic add_release(int unsigned n);
    repeat (n) queue_tick(3'b111);
  endtask

  task automatic add_press_runs(int unsigned n);
    int unsigned start;
    int unsigned len;
    button_t b;
    start = ticks_queued;
    while (ticks_queued - start < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          b = button_t'($urandom_range(1, 3));
          len = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 320) : $urandom_range(1, 40);
          if ($urandom_range(0, 3) == 0) begin
            add_hold(b, len / 2 + 1);
            b = button_t'($urandom_range(1, 3));
          end
          add_hold(b, len);
          add_release($urandom_range(1, 30));
        end
        7, 8: repeat ($urandom_range(1, 20)) queue_tick(levels_t'($urandom_range(0, 7)));
        default: begin
          add_hold(button_t'($urandom_range(1, 3)), $urandom_range(1, 3));
          add_release($urandom_range(1, 3));
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (tick_queue.size() != 0 || in_valid || awaited_samples.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_interval(logic [CFG_INDEX_W-1:0] idx, logic [TICK_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_INITIAL: iv_initial = value;
      REG_MEDIUM: iv_medium = value;
      REG_FAST: iv_fast = value;
      default: ;
    endcase
  endtask

  task automatic write_intervals(logic [TICK_W-1:0] a, logic [TICK_W-1:0] b,
                                 logic [TICK_W-1:0] c);
    write_interval(REG_INITIAL, a);
    write_interval(REG_MEDIUM, b);
    write_interval(REG_FAST, c);
  endtask

  task automatic run_phase(logic [TICK_W-1:0] a, logic [TICK_W-1:0] b, logic [TICK_W-1:0] c,
                           int unsigned n, int unsigned hold_off);
    write_intervals(a, b, c);
    hold_off_left = hold_off;
    add_press_runs(n);
    wait_drained();
  endtask

  // sender: bursts of ticks with random gaps
  always @(negedge clk) begin : drive_ticks
    logic offer;
    levels_t lv;
    offer = in_valid && !beat_taken;
    beat_taken = 1'b0;
    if (!rst && !offer) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (tick_queue.size() != 0) begin
        lv = tick_queue.pop_front();
        up_level <= lv.up;
        down_level <= lv.down;
        alarm_level <= lv.alarm;
        offer = 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
    in_valid <= offer;
  end

  // receiver: stall rate changes from stretch to stretch, plus long hold-offs
  always @(negedge clk) begin : drive_ready
    if (hold_off_left != 0) begin
      hold_off_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(16, 160);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end else begin
        mode_left--;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    sample_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        awaited_samples.push_back(predict_sample(levels_t'({up_level, down_level, alarm_level})));
        beat_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (awaited_samples.size() == 0) begin
          report_mismatch($sformatf("beat with nothing awaited: event_res %0d held_count %0d",
                                    event_res, held_count));
        end else begin
          want = awaited_samples.pop_front();
          if (event_res !== want.ev)
            report_mismatch($sformatf("event_res %0d, expected %0d", event_res, want.ev));
          if (held_count !== want.count)
            report_mismatch($sformatf("held_count %0d, expected %0d", held_count, want.count));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset intervals
    repeat (2) begin
      add_hold(button_t'($urandom_range(1, 3)), $urandom_range(60, 150));
      add_release($urandom_range(61, 90));
    end
    wait_drained();

    write_interval(REG_UNUSED, 16'h0005);
    write_intervals(16'd0, 16'd1, 16'd2);
    foreach (DIRECTED_TICKS[i]) queue_tick(DIRECTED_TICKS[i]);
    add_release(2);
    wait_drained();

    run_phase(16'd1, 16'd2, 16'd0, 120, 0);
    run_phase(16'd3, 16'd1, 16'd1, 120, 300);

    // press count saturation
    write_intervals(16'd0, 16'd0, 16'd0);
    add_hold(BTN_DOWN, 300);
    add_release(2);
    add_press_runs(80);
    wait_drained();

    run_phase(16'd2, 16'd5, 16'd3, 120, 0);
    run_phase(16'd1, 16'hFFFF, 16'd0, 120, 0);
    run_phase($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6), 120, 0);
    run_phase(16'd4, 16'd3, 16'd7, 120, 0);

    // widest interval, nothing is sampled
    write_intervals(16'hFFFF, 16'd2, 16'd1);
    add_release(40);
    repeat (20) queue_tick(levels_t'($urandom_range(0, 7)));
    wait_drained();

    repeat (4) @(posedge clk);
    if (awaited_samples.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_samples.size()));
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_CYCLES * 8);
    $display("TEST FAILED");
    $finish;
  end

endmodule
